FILE: hdl/rpn_pkg.sv
// rpn_pkg: shared constants, codes and controller/datapath link types
// for the rpn stack evaluator; no dependencies
package rpn_pkg;

  localparam int SYM_W           = 8;
  localparam int VALUE_W         = 48;
  localparam int STATUS_W        = 3;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [SYM_W-1:0] CH_END   = 8'h00;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  localparam logic [VALUE_W-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN = 48'h8000_0000_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_LEFT  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_OVER  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SYM_END,
    SYM_DIGIT,
    SYM_ADD,
    SYM_SUB,
    SYM_MUL,
    SYM_DIV,
    SYM_OTHER
  } sym_class_t;

  typedef enum logic [1:0] {
    OUT_ERR,
    OUT_EMPTY,
    OUT_TOP
  } out_src_t;

  // controller to datapath
  typedef struct packed {
    logic       load_sym;
    logic       rd_top;
    logic       rd_next;
    logic       cap_r;
    logic       cap_l;
    logic       push_digit;
    logic       write_res;
    logic       set_err;
    status_t    err_code;
    logic       mdu_start;
    logic       out_load;
    out_src_t   out_src;
    logic       clear;
  } rpn_cmd_t;

  // datapath to controller
  typedef struct packed {
    sym_class_t sym_class;
    logic       err_set;
    logic       depth_zero;
    logic       depth_lt2;
    logic       depth_full;
    logic       right_zero;
    logic       mdu_done;
    logic       out_free;
  } rpn_stat_t;

  function automatic sym_class_t classify(input logic [SYM_W-1:0] c);
    sym_class_t k;
    case (c) inside
      CH_END:             k = SYM_END;
      [CH_ZERO:CH_NINE]:  k = SYM_DIGIT;
      CH_PLUS:            k = SYM_ADD;
      CH_MINUS:           k = SYM_SUB;
      CH_STAR:            k = SYM_MUL;
      CH_SLASH:           k = SYM_DIV;
      default:            k = SYM_OTHER;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/rpn_mdu.sv
// rpn_mdu: iterative fixed-point multiply/divide unit, one bit per cycle
// depends on rpn_pkg
module rpn_mdu #(
  parameter int FRAC_BITS = rpn_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        div_mode,
  input  logic [rpn_pkg::VALUE_W-1:0] lhs,
  input  logic [rpn_pkg::VALUE_W-1:0] rhs,
  output logic                        done,
  output logic [rpn_pkg::VALUE_W-1:0] res
);

  localparam int VW = rpn_pkg::VALUE_W;
  localparam int NW = VW + FRAC_BITS;
  localparam int PW = 2 * VW;
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_t;

  mstate_t        state;
  logic           is_div;
  logic           neg;
  logic [VW-1:0]  mcand;
  logic [PW-1:0]  prod;
  logic [VW-1:0]  rem;
  logic [NW-1:0]  quo;
  logic [CW-1:0]  cnt;

  logic [VW-1:0]  lmag, rmag;
  logic [VW:0]    psum;
  logic [VW:0]    trial;
  logic [VW+1:0]  diff;
  logic           ge;
  logic [PW-1:0]  mul_sh;
  logic           sat;
  logic [VW-2:0]  mag;
  logic [VW-1:0]  fix_val;

  assign lmag = lhs[VW-1] ? (~lhs + VW'(1)) : lhs;
  assign rmag = rhs[VW-1] ? (~rhs + VW'(1)) : rhs;

  // shift-add multiply step
  assign psum = {1'b0, prod[PW-1:VW]} + {1'b0, mcand};

  // restoring divide step
  assign trial = {rem, quo[NW-1]};
  assign diff  = {1'b0, trial} - {2'b00, mcand};
  assign ge    = ~diff[VW+1];

  // final scaling, saturation and sign
  assign mul_sh = prod >> FRAC_BITS;
  assign sat    = is_div ? (|quo[NW-1:VW-1]) : (|mul_sh[PW-1:VW-1]);
  assign mag    = is_div ? quo[VW-2:0] : mul_sh[VW-2:0];

  always_comb begin
    if (sat) begin
      fix_val = neg ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
    end else if (neg) begin
      fix_val = ~{1'b0, mag} + VW'(1);
    end else begin
      fix_val = {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            is_div <= div_mode;
            neg    <= lhs[VW-1] ^ rhs[VW-1];
            rem    <= '0;
            if (div_mode) begin
              mcand <= rmag;
              quo   <= NW'(lmag) << FRAC_BITS;
              cnt   <= CW'(NW);
            end else begin
              mcand <= lmag;
              prod  <= {{VW{1'b0}}, rmag};
              cnt   <= CW'(VW);
            end
            state <= M_RUN;
          end
        end
        M_RUN: begin
          if (is_div) begin
            rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            quo <= {quo[NW-2:0], ge};
          end else if (prod[0]) begin
            prod <= {psum, prod[VW-1:1]};
          end else begin
            prod <= {1'b0, prod[PW-1:1]};
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= M_FIX;
          end
        end
        M_FIX: begin
          res   <= fix_val;
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/rpn_dp.sv
// rpn_dp: operand stack memory, operand registers, add/sub, mul/div unit
// and result register; depends on rpn_pkg and rpn_mdu
module rpn_dp #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rpn_pkg::SYM_W-1:0]    symbol,
  input  rpn_pkg::rpn_cmd_t            cmd,
  output rpn_pkg::rpn_stat_t           stat,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [rpn_pkg::VALUE_W-1:0]  value,
  output logic [rpn_pkg::STATUS_W-1:0] status
);

  localparam int VW = rpn_pkg::VALUE_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [VW-1:0]              mem [STACK_DEPTH];
  logic [VW-1:0]              rd_data;
  logic [rpn_pkg::SYM_W-1:0]  sym;
  logic [DW-1:0]              depth;
  rpn_pkg::status_t           err;
  logic [VW-1:0]              rop, lop;

  rpn_pkg::sym_class_t        cls;
  logic [DW-1:0]              dm1, dm2;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [VW-1:0]              wr_data;
  logic [rpn_pkg::SYM_W-1:0]  dig8;
  logic [VW-1:0]              dig_val;
  logic [VW:0]                as_sum;
  logic [VW-1:0]              as_res;
  logic [VW-1:0]              op_res;
  logic                       mdu_done;
  logic [VW-1:0]              mdu_res;
  logic                       is_md;

  assign cls     = rpn_pkg::classify(sym);
  assign dm1     = depth - DW'(1);
  assign dm2     = depth - DW'(2);
  assign rd_addr = cmd.rd_next ? dm2[AW-1:0] : dm1[AW-1:0];
  assign wr_addr = cmd.push_digit ? depth[AW-1:0] : dm2[AW-1:0];

  assign dig8    = sym - rpn_pkg::CH_ZERO;
  assign dig_val = VW'(dig8[3:0]) << FRAC_BITS;

  // add/sub with saturation on the 49-bit sum
  assign as_sum = (cls == rpn_pkg::SYM_SUB) ? ({lop[VW-1], lop} - {rop[VW-1], rop})
                                            : ({lop[VW-1], lop} + {rop[VW-1], rop});
  always_comb begin
    if (as_sum[VW] != as_sum[VW-1]) begin
      as_res = as_sum[VW] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
    end else begin
      as_res = as_sum[VW-1:0];
    end
  end

  assign is_md   = (cls == rpn_pkg::SYM_MUL) || (cls == rpn_pkg::SYM_DIV);
  assign op_res  = is_md ? mdu_res : as_res;
  assign wr_data = cmd.push_digit ? dig_val : op_res;

  rpn_mdu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mdu (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mdu_start),
    .div_mode (cls == rpn_pkg::SYM_DIV),
    .lhs      (lop),
    .rhs      (rop),
    .done     (mdu_done),
    .res      (mdu_res)
  );

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_digit || cmd.write_res) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_top || cmd.rd_next) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sym) begin
      sym <= symbol;
    end
    if (cmd.cap_r) begin
      rop <= rd_data;
    end
    if (cmd.cap_l) begin
      lop <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      err   <= rpn_pkg::ST_OK;
    end else begin
      if (cmd.clear) begin
        depth <= '0;
      end else if (cmd.push_digit) begin
        depth <= depth + DW'(1);
      end else if (cmd.write_res) begin
        depth <= dm1;
      end
      if (cmd.clear) begin
        err <= rpn_pkg::ST_OK;
      end else if (cmd.set_err) begin
        err <= cmd.err_code;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_src)
        rpn_pkg::OUT_ERR: begin
          value  <= '0;
          status <= err;
        end
        rpn_pkg::OUT_EMPTY: begin
          value  <= '0;
          status <= rpn_pkg::ST_UNDER;
        end
        rpn_pkg::OUT_TOP: begin
          value  <= rd_data;
          status <= (depth != DW'(1)) ? rpn_pkg::ST_LEFT : rpn_pkg::ST_OK;
        end
        default: begin
          value  <= '0;
          status <= rpn_pkg::ST_OK;
        end
      endcase
    end
  end

  assign stat.sym_class  = cls;
  assign stat.err_set    = (err != rpn_pkg::ST_OK);
  assign stat.depth_zero = (depth == '0);
  assign stat.depth_lt2  = (depth < DW'(2));
  assign stat.depth_full = (depth >= DW'(STACK_DEPTH));
  assign stat.right_zero = (rop == '0);
  assign stat.mdu_done   = mdu_done;
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

FILE: hdl/rpn_ctrl.sv
// rpn_ctrl: sequencing state machine for the rpn stack evaluator
// depends on rpn_pkg
module rpn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpn_pkg::rpn_stat_t stat,
  output rpn_pkg::rpn_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TOUT,
    S_RDR,
    S_RDL,
    S_EXEC,
    S_MWAIT
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.err_code = rpn_pkg::ST_OK;
    cmd.out_src  = rpn_pkg::OUT_ERR;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sym = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.sym_class == rpn_pkg::SYM_END) begin
          if (stat.err_set || stat.depth_zero) begin
            if (stat.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_src  = stat.err_set ? rpn_pkg::OUT_ERR : rpn_pkg::OUT_EMPTY;
              cmd.clear    = 1'b1;
              state_next   = S_IDLE;
            end
          end else begin
            cmd.rd_top = 1'b1;
            state_next = S_TOUT;
          end
        end else if (stat.err_set) begin
          state_next = S_IDLE;
        end else begin
          case (stat.sym_class)
            rpn_pkg::SYM_DIGIT: begin
              if (stat.depth_full) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = rpn_pkg::ST_OVER;
              end else begin
                cmd.push_digit = 1'b1;
              end
              state_next = S_IDLE;
            end
            rpn_pkg::SYM_ADD, rpn_pkg::SYM_SUB, rpn_pkg::SYM_MUL, rpn_pkg::SYM_DIV: begin
              if (stat.depth_lt2) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = rpn_pkg::ST_UNDER;
                state_next   = S_IDLE;
              end else begin
                cmd.rd_top = 1'b1;
                state_next = S_RDR;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_TOUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = rpn_pkg::OUT_TOP;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RDR: begin
        cmd.cap_r   = 1'b1;
        cmd.rd_next = 1'b1;
        state_next  = S_RDL;
      end
      S_RDL: begin
        cmd.cap_l  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        case (stat.sym_class)
          rpn_pkg::SYM_ADD, rpn_pkg::SYM_SUB: begin
            cmd.write_res = 1'b1;
            state_next    = S_IDLE;
          end
          rpn_pkg::SYM_DIV: begin
            if (stat.right_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpn_pkg::ST_DIVZ;
              state_next   = S_IDLE;
            end else begin
              cmd.mdu_start = 1'b1;
              state_next    = S_MWAIT;
            end
          end
          rpn_pkg::SYM_MUL: begin
            cmd.mdu_start = 1'b1;
            state_next    = S_MWAIT;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_MWAIT: begin
        if (stat.mdu_done) begin
          cmd.write_res = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/rpn_stack_evaluator.sv
// rpn_stack_evaluator: top level of the reverse polish expression evaluator
// depends on rpn_pkg, rpn_ctrl, rpn_dp (which holds rpn_mdu)
//
//   channel   direction   handshake              payload
//   input     in          in_valid / in_stall    symbol[7:0]
//   result    out         out_valid / out_stall  value[47:0] (signed), status[2:0]
//
// one item is worked at a time; in_stall is high whenever the controller is busy
// digit or ignored byte: handled in the decode state; + or -: two stack reads through the
// single registered read port of the stack memory, then the write back
// * and / are worked by the bit-serial multiply/divide unit (48 or 48 + FRAC_BITS steps)
// terminator: waits while the result register is still held by out_stall
// synchronous active-high reset clears depth, error and valid flags; no clearing pass
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // expression bytes
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rpn_pkg::SYM_W-1:0]    symbol,
  // one result per terminator
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rpn_pkg::VALUE_W-1:0]  value,
  output logic [rpn_pkg::STATUS_W-1:0] status
);

  // command and status link between sequencer and datapath
  rpn_pkg::rpn_cmd_t  cmd;
  rpn_pkg::rpn_stat_t stat;

  // sequencer: decodes the held byte and steps reads, arithmetic and write back
  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: stack memory, depth and error registers, arithmetic, result register
  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .symbol    (symbol),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .value     (value),
    .status    (status)
  );

endmodule
